[rtl/smdu_pkg.sv]
// ----------------------------------------------------------------------------
// smdu_pkg
// Shared types and constants for the signed multiply / divide unit.
// ----------------------------------------------------------------------------
package smdu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    localparam logic [1:0] CMD_MUL = 2'd0;
    localparam logic [1:0] CMD_QUO = 2'd1;
    localparam logic [1:0] CMD_REM = 2'd2;

    typedef struct packed {
        logic [1:0]                   cmd;
        logic signed [DATA_WIDTH-1:0] operand_a;
        logic signed [DATA_WIDTH-1:0] operand_b;
    } cmd_word_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result_value;
        logic                         divide_by_zero;
    } rsp_word_t;

    // Controls from the sequencer to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } ctrl_t;

endpackage

[rtl/smdu_seq.sv]
// ----------------------------------------------------------------------------
// smdu_seq
// Sequencer: load, one pass per operand bit, then a sign fixing state.
// ----------------------------------------------------------------------------
module smdu_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           out_free,
    output logic           idle,
    output smdu_pkg::ctrl_t ctrl
);
    import smdu_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIX  = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ctrl.load   = 1'b0;
        ctrl.step   = 1'b0;
        ctrl.finish = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    cnt_next   = CNT_W'(DATA_WIDTH - 1);
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                ctrl.step = 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                // Hold the finished word until the output register is free.
                if (out_free)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[rtl/smdu_dp.sv]
// ----------------------------------------------------------------------------
// smdu_dp
// Datapath: magnitude load, shared add/subtract step, sign restore.
// ----------------------------------------------------------------------------
module smdu_dp (
    input  logic                 clk,
    input  smdu_pkg::ctrl_t      ctrl,
    input  smdu_pkg::cmd_word_t  cmd_word,
    output smdu_pkg::rsp_word_t  rsp_word
);
    import smdu_pkg::*;

    localparam int W = DATA_WIDTH;

    logic [1:0]   op_reg;
    logic         neg_reg;
    logic         dz_reg;
    logic [W-1:0] acc_reg;   // product accumulator or partial remainder
    logic [W-1:0] opb_reg;   // shifted multiplicand or divisor
    logic [W-1:0] shf_reg;   // multiplier bits or dividend/quotient bits

    logic         na;
    logic         nb;
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    logic         is_mul;
    logic [W:0]   add_x;
    logic [W:0]   add_y;
    logic [W:0]   add_sum;
    logic [W-1:0] mag;
    logic [W-1:0] signed_mag;

    // Input magnitudes, taken as unsigned so the most negative value is exact.
    assign na = cmd_word.operand_a[W-1];
    assign nb = cmd_word.operand_b[W-1];
    assign ma = na ? (~cmd_word.operand_a + 1'b1) : cmd_word.operand_a;
    assign mb = nb ? (~cmd_word.operand_b + 1'b1) : cmd_word.operand_b;

    // The one shared adder: add for multiply, subtract for divide.
    assign is_mul  = (op_reg == CMD_MUL);
    assign add_x   = is_mul ? {1'b0, acc_reg} : {acc_reg, shf_reg[W-1]};
    assign add_y   = {1'b0, opb_reg} ^ {(W+1){!is_mul}};
    assign add_sum = add_x + add_y + {{W{1'b0}}, !is_mul};

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            op_reg  <= cmd_word.cmd;
            neg_reg <= (cmd_word.cmd == CMD_REM) ? na : (na ^ nb);
            dz_reg  <= ((cmd_word.cmd == CMD_QUO) || (cmd_word.cmd == CMD_REM))
                       && (mb == '0);
            acc_reg <= '0;
            if (cmd_word.cmd == CMD_MUL)
            begin
                opb_reg <= ma;
                shf_reg <= mb;
            end
            else
            begin
                opb_reg <= mb;
                shf_reg <= ma;
            end
        end
        else if (ctrl.step)
        begin
            if (is_mul)
            begin
                if (shf_reg[0])
                begin
                    acc_reg <= add_sum[W-1:0];
                end
                opb_reg <= {opb_reg[W-2:0], 1'b0};
                shf_reg <= {1'b0, shf_reg[W-1:1]};
            end
            else
            begin
                // Restoring step: keep the difference when it did not borrow.
                acc_reg <= add_sum[W] ? add_x[W-1:0] : add_sum[W-1:0];
                shf_reg <= {shf_reg[W-2:0], !add_sum[W]};
            end
        end
    end

    always_comb
    begin
        case (op_reg)
            CMD_MUL: mag = acc_reg;
            CMD_QUO: mag = shf_reg;
            CMD_REM: mag = acc_reg;
            default: mag = '0;
        endcase
    end

    assign signed_mag = neg_reg ? (~mag + 1'b1) : mag;

    always_comb
    begin
        rsp_word.divide_by_zero = dz_reg;
        if (dz_reg || !(op_reg inside {CMD_MUL, CMD_QUO, CMD_REM}))
        begin
            rsp_word.result_value = '0;
        end
        else
        begin
            rsp_word.result_value = signed_mag;
        end
    end

endmodule

[rtl/signed_mul_div_unit_top.sv]
// Each word passes through a load step, one shared add/subtract pass per operand
// bit, and a sign step that waits until the output register is free.
// A new word is taken only after the previous one finishes; one adder serves all.
// A new word is accepted while the previous result still waits at the output.
// Reset (rst_n low, asynchronous) empties the output and idles the sequencer.
// ----------------------------------------------------------------------------
// signed_mul_div_unit_top
// Sequential signed multiplier and divider with one shared adder.
// ----------------------------------------------------------------------------
module signed_mul_div_unit_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  smdu_pkg::cmd_word_t cmd_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output smdu_pkg::rsp_word_t rsp_word
);
    import smdu_pkg::*;

    logic      idle;
    logic      start;
    logic      out_free;
    ctrl_t     ctrl;
    rsp_word_t dp_word;
    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    rsp_word_t rsp_word_reg;

    // A command word is taken only when the sequencer is idle; the output
    // register decouples the result side, so a waiting result does not block.
    assign cmd_stall = !idle;
    assign start     = cmd_valid && idle;

    // The output register can take a new word when empty or being drained.
    assign out_free = !rsp_valid_reg || !rsp_stall;

    smdu_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .out_free (out_free),
        .idle     (idle),
        .ctrl     (ctrl)
    );

    smdu_dp u_dp (
        .clk      (clk),
        .ctrl     (ctrl),
        .cmd_word (cmd_word),
        .rsp_word (dp_word)
    );

    // The sign is restored in the final cycle and the word lands here.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctrl.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            rsp_word_reg <= dp_word;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule
